// ===== rtl/tes_pkg.sv =====
// Shared types and constants for the timed event scheduler.
// No dependencies; every other file imports this package.
package tes_pkg;

   localparam int QDEPTH = 32;
   localparam int IDX_W = $clog2(QDEPTH);
   localparam int CNT_W = $clog2(QDEPTH + 1);
   localparam int TYPE_COUNT = 64;
   localparam logic [15:0] DEFAULT_SLICE = 16'd20000;

   typedef enum logic [1:0] {
      KIND_SCHEDULE = 2'd0,
      KIND_ADVANCE  = 2'd1,
      KIND_REMOVE   = 2'd2,
      KIND_IDLE     = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        type_ok;
      logic [31:0] delay;
      logic [5:0]  evt_code;
      logic [63:0] userdata;
      logic [15:0] remaining;
   } cmd_type;

   typedef struct packed {
      logic        fired;
      logic [5:0]  fired_type;
      logic [63:0] fired_data;
      logic [31:0] lateness;
      logic [15:0] countdown;
      logic [62:0] ticks;
      logic [62:0] idle_total;
      logic        dropped;
      logic [5:0]  removed_count;
      logic        last;
   } rsp_type;

endpackage

// ===== rtl/timed_event_scheduler_core.sv =====
// Top level of the timed event scheduler: front end, queue and command engine.
// Depends on tes_pkg, tes_front and tes_engine.
//
//  channel | dir | handshake             | content
//  req_    | in  | req_tvalid/req_tready  | tuser: kind; tdata: delay, evt_code, userdata, remaining
//  rsp_    | out | rsp_tvalid/rsp_tready  | tuser: fired; tdata: event and timer status; tlast: last
//  csr_    | in  | csr_we                 | csr_wdata: max_slice
//
// The engine scans the queue one entry per cycle through one read port, except
// that a remove holds its index on a match while the slot closes up.
// Reset is synchronous: empty queue, zero timer, slice of 20000 ticks.
// A two-deep command queue keeps accepting, until full, while the engine waits on rsp_tready.
module timed_event_scheduler_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // delay[31:0], evt_code[37:32], userdata[101:38], remaining[117:102], zeros
   input  logic [119:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // fired_type[5:0], fired_data[69:6], lateness[101:70], countdown[117:102],
   // ticks[180:118], idle_total[243:181], dropped[244], removed_count[250:245], zeros
   output logic [255:0] rsp_tdata,
   // fired[0]
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata
);
   import tes_pkg::*;

   logic [15:0] max_slice_ff;
   logic        cmd_valid;
   cmd_type     cmd;
   logic        cmd_pop;
   rsp_type     rsp;

   // Hold max_slice; the user must write it only while the engine is idle (not enforced here).
   always_ff @(posedge clock) begin
      if (reset) begin
         max_slice_ff <= DEFAULT_SLICE;
      end else if (csr_we) begin
         max_slice_ff <= csr_wdata;
      end
   end

   tes_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   tes_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .max_slice (max_slice_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // Pack the result transaction.
   assign rsp_tdata = {5'd0, rsp.removed_count, rsp.dropped, rsp.idle_total, rsp.ticks,
                       rsp.countdown, rsp.lateness, rsp.fired_data, rsp.fired_type};
   assign rsp_tuser = rsp.fired;
   assign rsp_tlast = rsp.last;

endmodule

// ===== rtl/tes_front.sv =====
// Front end: accepts request transactions, classifies them and queues them.
// Depends on tes_pkg.
module tes_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [119:0]     req_tdata,
   input  logic [1:0]       req_tuser,
   output logic             cmd_valid,
   output tes_pkg::cmd_type cmd,
   input  logic             cmd_pop
);
   import tes_pkg::*;

   cmd_type    fifo_ff [2];
   logic       wptr_ff;
   logic       rptr_ff;
   logic [1:0] cnt_ff;
   cmd_type    cmd_in;
   logic       push;

   always_comb begin
      cmd_in.kind      = kind_type'(req_tuser);
      cmd_in.delay     = req_tdata[31:0];
      cmd_in.evt_code  = req_tdata[37:32];
      cmd_in.userdata  = req_tdata[101:38];
      cmd_in.remaining = req_tdata[117:102];
      cmd_in.type_ok   = ({2'b00, req_tdata[37:32]} < 8'(TYPE_COUNT));
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign cmd        = fifo_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wptr_ff] <= cmd_in;
      end
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (cmd_pop) begin
            rptr_ff <= ~rptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, cmd_pop};
      end
   end

endmodule

// ===== rtl/tes_engine.sv =====
// Back end: event queue, timer state and the sequencer that runs each command.
// Depends on tes_pkg.
module tes_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      max_slice,
   input  logic             cmd_valid,
   input  tes_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tes_pkg::rsp_type rsp
);
   import tes_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCHED_CUR, ST_SCHED_WR, ST_ADV_TIMER, ST_ADV_SCAN, ST_ADV_SLICE,
      ST_FIRE_INIT, ST_FIRE_SCAN, ST_FIRE_EMIT, ST_REM_SCAN, ST_EMIT
   } state_type;

   state_type        state_ff;
   logic [63:0]      timer_ff;
   logic [15:0]      slice_ff;
   logic             sane_ff;
   logic [31:0]      order_ff;
   logic [63:0]      idle_ff;
   logic [CNT_W-1:0] count_ff;

   logic [63:0]      due_ff   [QDEPTH];
   logic [31:0]      ord_ff   [QDEPTH];
   logic [63:0]      data_ff  [QDEPTH];
   logic [5:0]       type_ff  [QDEPTH];

   cmd_type          cur_ff;
   logic [15:0]      cd_ff;
   logic             dropped_ff;
   logic [CNT_W-1:0] removed_ff;
   logic [63:0]      now_ff;
   logic [CNT_W-1:0] scan_ff;
   logic [CNT_W-1:0] ndue_ff;
   logic             have_min_ff;
   logic [63:0]      min_due_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [63:0]      best_due_ff;
   logic [31:0]      best_ord_ff;
   logic [63:0]      best_data_ff;
   logic [5:0]       best_type_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic             out_free;
   logic             emit_now;
   logic [IDX_W-1:0] rd_idx;
   logic             scan_live;
   logic [63:0]      rd_due;
   logic [31:0]      rd_ord;
   logic [16:0]      tick_diff;
   logic [63:0]      ticks_in;
   logic [16:0]      exec_diff;
   logic [63:0]      exec_in;
   logic [63:0]      late_raw;
   logic [31:0]      late_in;
   logic [63:0]      gap_in;
   logic [31:0]      clip_in;
   logic             drop_en;
   logic [IDX_W-1:0] drop_idx;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_now  = out_free && ((state_ff == ST_FIRE_EMIT) || (state_ff == ST_EMIT));
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid;

   assign rd_idx    = scan_ff[IDX_W-1:0];
   assign scan_live = (scan_ff < count_ff);
   assign rd_due    = due_ff[rd_idx];
   assign rd_ord    = ord_ff[rd_idx];

   // Ticks seen by the CPU: timer plus executed part of the slice while running.
   assign tick_diff = {1'b0, slice_ff} - {1'b0, cd_ff};
   assign ticks_in  = sane_ff ? timer_ff : timer_ff + {{47{tick_diff[16]}}, tick_diff};
   assign exec_diff = {1'b0, slice_ff} - {1'b0, cur_ff.remaining};
   assign exec_in   = {{47{exec_diff[16]}}, exec_diff};
   assign late_raw  = timer_ff - best_due_ff;
   assign late_in   = (late_raw[63:32] != 32'd0) ? 32'hFFFF_FFFF : late_raw[31:0];
   assign gap_in    = min_due_ff - timer_ff;
   assign clip_in   = cur_ff.delay[31] ? 32'd0 : cur_ff.delay;

   assign drop_en  = ((state_ff == ST_FIRE_EMIT) && out_free) ||
                     ((state_ff == ST_REM_SCAN) && scan_live &&
                      (type_ff[rd_idx] == cur_ff.evt_code));
   assign drop_idx = (state_ff == ST_FIRE_EMIT) ? best_idx_ff : rd_idx;

   // Entry storage: append on schedule, shift down over a dropped slot.
   always_ff @(posedge clock) begin
      if (state_ff == ST_SCHED_WR) begin
         due_ff[count_ff[IDX_W-1:0]]  <= now_ff + {{32{cur_ff.delay[31]}}, cur_ff.delay};
         ord_ff[count_ff[IDX_W-1:0]]  <= order_ff;
         data_ff[count_ff[IDX_W-1:0]] <= cur_ff.userdata;
         type_ff[count_ff[IDX_W-1:0]] <= cur_ff.evt_code;
      end else if (drop_en) begin
         for (int i = 0; i < QDEPTH - 1; i++) begin
            if (IDX_W'(i) >= drop_idx) begin
               due_ff[i]  <= due_ff[i+1];
               ord_ff[i]  <= ord_ff[i+1];
               data_ff[i] <= data_ff[i+1];
               type_ff[i] <= type_ff[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         timer_ff     <= 64'd0;
         slice_ff     <= DEFAULT_SLICE;
         sane_ff      <= 1'b1;
         order_ff     <= 32'd0;
         idle_ff      <= 64'd0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !emit_now) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  cur_ff     <= cmd;
                  cd_ff      <= (cmd.kind == KIND_IDLE) ? 16'd0 : cmd.remaining;
                  dropped_ff <= (cmd.kind == KIND_SCHEDULE) && cmd.type_ok &&
                                (count_ff >= CNT_W'(QDEPTH));
                  removed_ff <= '0;
                  scan_ff    <= '0;
                  unique case (cmd.kind)
                     KIND_SCHEDULE: begin
                        if (!cmd.type_ok) begin
                           state_ff <= ST_EMIT;
                        end else if (count_ff >= CNT_W'(QDEPTH)) begin
                           state_ff <= ST_EMIT;
                        end else begin
                           state_ff <= ST_SCHED_CUR;
                        end
                     end
                     KIND_ADVANCE: begin
                        state_ff <= ST_ADV_TIMER;
                     end
                     KIND_REMOVE: begin
                        state_ff <= cmd.type_ok ? ST_REM_SCAN : ST_EMIT;
                     end
                     KIND_IDLE: begin
                        idle_ff  <= idle_ff + {48'd0, cmd.remaining};
                        state_ff <= ST_EMIT;
                     end
                     default: begin
                        state_ff <= ST_EMIT;
                     end
                  endcase
               end
            end
            ST_SCHED_CUR: begin
               now_ff   <= sane_ff ? timer_ff : timer_ff + exec_in;
               state_ff <= ST_SCHED_WR;
            end
            ST_SCHED_WR: begin
               count_ff <= count_ff + 1'b1;
               order_ff <= order_ff + 32'd1;
               // Pull the slice end in when the new event lands earlier.
               if (!sane_ff && ({16'd0, cur_ff.remaining} > clip_in)) begin
                  slice_ff <= slice_ff - (cur_ff.remaining - clip_in[15:0]);
                  cd_ff    <= clip_in[15:0];
               end
               state_ff <= ST_EMIT;
            end
            ST_ADV_TIMER: begin
               timer_ff    <= timer_ff + exec_in;
               sane_ff     <= 1'b0;
               ndue_ff     <= '0;
               have_min_ff <= 1'b0;
               state_ff    <= ST_ADV_SCAN;
            end
            ST_ADV_SCAN: begin
               if (scan_live) begin
                  if (!($signed(timer_ff) < $signed(rd_due))) begin
                     ndue_ff <= ndue_ff + 1'b1;
                  end else if (!have_min_ff || ($signed(rd_due) < $signed(min_due_ff))) begin
                     min_due_ff  <= rd_due;
                     have_min_ff <= 1'b1;
                  end
                  scan_ff <= scan_ff + 1'b1;
               end else begin
                  state_ff <= ST_ADV_SLICE;
               end
            end
            ST_ADV_SLICE: begin
               if (have_min_ff && (gap_in < {48'd0, max_slice})) begin
                  slice_ff <= gap_in[15:0];
                  cd_ff    <= gap_in[15:0];
               end else begin
                  slice_ff <= max_slice;
                  cd_ff    <= max_slice;
               end
               state_ff <= (ndue_ff == '0) ? ST_EMIT : ST_FIRE_INIT;
            end
            ST_FIRE_INIT: begin
               best_idx_ff  <= '0;
               best_due_ff  <= due_ff[0];
               best_ord_ff  <= ord_ff[0];
               best_data_ff <= data_ff[0];
               best_type_ff <= type_ff[0];
               scan_ff      <= CNT_W'(1);
               state_ff     <= ST_FIRE_SCAN;
            end
            ST_FIRE_SCAN: begin
               if (scan_live) begin
                  if (($signed(rd_due) < $signed(best_due_ff)) ||
                      ((rd_due == best_due_ff) && (rd_ord < best_ord_ff))) begin
                     best_idx_ff  <= rd_idx;
                     best_due_ff  <= rd_due;
                     best_ord_ff  <= rd_ord;
                     best_data_ff <= data_ff[rd_idx];
                     best_type_ff <= type_ff[rd_idx];
                  end
                  scan_ff <= scan_ff + 1'b1;
               end else begin
                  state_ff <= ST_FIRE_EMIT;
               end
            end
            ST_FIRE_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_ff.fired         <= 1'b1;
                  rsp_ff.fired_type    <= best_type_ff;
                  rsp_ff.fired_data    <= best_data_ff;
                  rsp_ff.lateness      <= late_in;
                  rsp_ff.countdown     <= cd_ff;
                  rsp_ff.ticks         <= ticks_in[62:0];
                  rsp_ff.idle_total    <= idle_ff[62:0];
                  rsp_ff.dropped       <= 1'b0;
                  rsp_ff.removed_count <= '0;
                  rsp_ff.last          <= (ndue_ff == CNT_W'(1));
                  count_ff             <= count_ff - 1'b1;
                  ndue_ff              <= ndue_ff - 1'b1;
                  state_ff <= (ndue_ff == CNT_W'(1)) ? ST_IDLE : ST_FIRE_INIT;
               end
            end
            ST_REM_SCAN: begin
               if (scan_live) begin
                  // On a match the slot closes up, so hold the index.
                  if (drop_en) begin
                     count_ff   <= count_ff - 1'b1;
                     removed_ff <= removed_ff + 1'b1;
                  end else begin
                     scan_ff <= scan_ff + 1'b1;
                  end
               end else begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_ff.fired         <= 1'b0;
                  rsp_ff.fired_type    <= '0;
                  rsp_ff.fired_data    <= '0;
                  rsp_ff.lateness      <= '0;
                  rsp_ff.countdown     <= cd_ff;
                  rsp_ff.ticks         <= ticks_in[62:0];
                  rsp_ff.idle_total    <= idle_ff[62:0];
                  rsp_ff.dropped       <= dropped_ff;
                  rsp_ff.removed_count <= 6'(removed_ff);
                  rsp_ff.last          <= 1'b1;
                  state_ff             <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QDEPTH))
      else $error("queue count above depth");
   a_fire_has_due: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIRE_EMIT) |-> (ndue_ff != '0) && (count_ff != '0))
      else $error("fire with no due event");
   a_adv_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADV_TIMER) |=> !sane_ff)
      else $error("advance left timer sane");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (state_ff != ST_IDLE))
      else $error("command popped without dispatch");
`endif

endmodule

// ===== sim/timed_event_scheduler_core_test.sv =====
// Self-checking testbench for timed_event_scheduler_core: directed table, queue fill, then random items,
// each result checked against an event queue predictor kept in the testbench.
// Depends on tes_pkg and the RTL of timed_event_scheduler_core.
module timed_event_scheduler_core_test;
   import tes_pkg::*;

   localparam int STALL_LIMIT = 2000000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // delay[31:0], evt_code[37:32], userdata[101:38], remaining[117:102], zeros
   logic [119:0] req_tdata;
   // kind[1:0]
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // fired_type[5:0], fired_data[69:6], lateness[101:70], countdown[117:102],
   // ticks[180:118], idle_total[243:181], dropped[244], removed_count[250:245], zeros
   logic [255:0] rsp_tdata;
   // fired[0]
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we;
   logic [15:0]  csr_wdata;

   timed_event_scheduler_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // One stimulus transaction. A row with has_want set also carries the first
   // result, typed in by hand, which must agree with the predictor.
   typedef struct {
      kind_type    kind;
      logic [31:0] delay;
      logic [5:0]  evt_code;
      logic [63:0] userdata;
      logic [15:0] remaining;
      bit          has_want;
      rsp_type     want;
   } step_type;

   // Predictor state: the scheduler as the testbench sees it.
   logic [15:0] p_max_slice;
   logic [63:0] p_timer;
   logic [15:0] p_slice;
   logic        p_sane;
   logic [31:0] p_order;
   logic [63:0] p_idle;
   int          p_count;
   logic [63:0] q_due[QDEPTH];
   logic [31:0] q_order[QDEPTH];
   logic [63:0] q_data[QDEPTH];
   logic [5:0]  q_type[QDEPTH];

   rsp_type pending_rsp[$];
   int      mismatches;
   int      cycle_count = 0;
   bit      timed_out;

   function automatic bit due_before(logic [63:0] a, logic [63:0] b);
      return $signed(a) < $signed(b);
   endfunction

   function automatic int earliest_slot();
      int best;
      best = 0;
      for (int i = 1; i < p_count; i++)
         if (due_before(q_due[i], q_due[best]) ||
             (q_due[i] == q_due[best] && q_order[i] < q_order[best]))
            best = i;
      return best;
   endfunction

   function automatic void drop_entry(int s);
      for (int i = s; i + 1 < p_count; i++) begin
         q_due[i] = q_due[i + 1];
         q_order[i] = q_order[i + 1];
         q_data[i] = q_data[i + 1];
         q_type[i] = q_type[i + 1];
      end
      p_count--;
   endfunction

   function automatic logic [63:0] now_ticks(logic [15:0] cd);
      logic [63:0] run;
      run = {48'd0, p_slice} - {48'd0, cd};
      return p_sane ? p_timer : p_timer + run;
   endfunction

   function automatic void predictor_reset();
      p_max_slice = DEFAULT_SLICE;
      p_timer = '0;
      p_slice = DEFAULT_SLICE;
      p_sane = 1'b1;
      p_order = '0;
      p_idle = '0;
      p_count = 0;
   endfunction

   // Work out the results of one transaction and queue them; return the first.
   function automatic rsp_type predict_schedule_step(step_type st);
      rsp_type     outs[$];
      rsp_type     r;
      logic [15:0] cd;
      logic [63:0] dly, due, late, gap, clip, tk;
      logic        dropped;
      logic [5:0]  removed;
      int          s, i;
      cd = st.remaining;
      dly = {{32{st.delay[31]}}, st.delay};
      dropped = 1'b0;
      removed = '0;
      case (st.kind)
         KIND_SCHEDULE: begin
            if (p_count >= QDEPTH) begin
               dropped = 1'b1;
            end else begin
               due = now_ticks(st.remaining) + dly;
               if (!p_sane) begin
                  clip = dly[63] ? 64'd0 : dly;
                  if ({48'd0, st.remaining} > clip) begin
                     p_slice = p_slice - (st.remaining - clip[15:0]);
                     cd = clip[15:0];
                  end
               end
               q_due[p_count] = due;
               q_order[p_count] = p_order;
               q_data[p_count] = st.userdata;
               q_type[p_count] = st.evt_code;
               p_count++;
               p_order++;
            end
         end
         KIND_ADVANCE: begin
            p_timer = p_timer + ({48'd0, p_slice} - {48'd0, st.remaining});
            p_slice = p_max_slice;
            p_sane = 1'b1;
            while (p_count > 0) begin
               s = earliest_slot();
               if (due_before(p_timer, q_due[s]))
                  break;
               late = p_timer - q_due[s];
               r = '0;
               r.fired = 1'b1;
               r.fired_type = q_type[s];
               r.fired_data = q_data[s];
               r.lateness = (late > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : late[31:0];
               outs = {outs, r};
               drop_entry(s);
            end
            p_sane = 1'b0;
            if (p_count > 0) begin
               gap = q_due[earliest_slot()] - p_timer;
               p_slice = (gap < {48'd0, p_max_slice}) ? gap[15:0] : p_max_slice;
            end
            cd = p_slice;
         end
         KIND_REMOVE: begin
            i = 0;
            while (i < p_count) begin
               if (q_type[i] == st.evt_code) begin
                  drop_entry(i);
                  removed++;
               end else begin
                  i++;
               end
            end
         end
         default: begin
            p_idle = p_idle + {48'd0, st.remaining};
            cd = '0;
         end
      endcase
      if (outs.size() == 0) begin
         r = '0;
         outs = {outs, r};
      end
      tk = now_ticks(cd);
      foreach (outs[k]) begin
         outs[k].countdown = cd;
         outs[k].ticks = tk[62:0];
         outs[k].idle_total = p_idle[62:0];
         outs[k].dropped = dropped;
         outs[k].removed_count = removed;
         outs[k].last = (k == outs.size() - 1);
         pending_rsp = {pending_rsp, outs[k]};
      end
      return outs[0];
   endfunction

   function automatic rsp_type unpack_rsp();
      rsp_type r;
      r.fired = rsp_tuser;
      r.fired_type = rsp_tdata[5:0];
      r.fired_data = rsp_tdata[69:6];
      r.lateness = rsp_tdata[101:70];
      r.countdown = rsp_tdata[117:102];
      r.ticks = rsp_tdata[180:118];
      r.idle_total = rsp_tdata[243:181];
      r.dropped = rsp_tdata[244];
      r.removed_count = rsp_tdata[250:245];
      r.last = rsp_tlast;
      return r;
   endfunction

   function automatic void report_mismatch(string what, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %p actual %p", what, want, got);
   endfunction

   // Short gaps mostly, a long one now and then, none at all in some stretches.
   function automatic int gap_cycles(bit quiet);
      if (quiet)
         return 0;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return 0;
         5, 6, 7, 8:    return $urandom_range(1, 3);
         default:       return $urandom_range(10, 40);
      endcase
   endfunction

   bit rsp_quiet;

   // Response side: random backpressure, compare every accepted transaction.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      int      hold;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = unpack_rsp();
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected result", '0, got);
         end else begin
            want = pending_rsp.pop_front();
            if (want !== got)
               report_mismatch("result field", want, got);
         end
      end
      hold = gap_cycles(rsp_quiet);
      rsp_tready <= (hold == 0) || ($urandom_range(3) == 0);
   end

   step_type    dir_rows[$];
   bit          req_quiet;

   task automatic wait_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   // Drive one transaction and hold it until the handshake completes.
   // Valid stays high after the handshake; a drain, or a gap before the next step, drops it.
   task automatic send_step(step_type st);
      rsp_type first;
      int      gap;
      gap = gap_cycles(req_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         wait_cycles(gap);
      end
      req_tvalid <= 1'b1;
      req_tuser <= st.kind;
      req_tdata <= {2'b00, st.remaining, st.userdata, st.evt_code, st.delay};
      do @(posedge clock); while (!req_tready);
      first = predict_schedule_step(st);
      if (st.has_want && first !== st.want)
         report_mismatch("directed row", st.want, first);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      // let the engine settle before anything else is driven
      wait_cycles(200);
   endtask

   task automatic write_max_slice(logic [15:0] v);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      p_max_slice = v;
   endtask

   function automatic step_type mk(kind_type k, logic [31:0] d, logic [5:0] t,
                                   logic [63:0] u, logic [15:0] r);
      step_type st;
      st.kind = k;
      st.delay = d;
      st.evt_code = t;
      st.userdata = u;
      st.remaining = r;
      st.has_want = 1'b0;
      st.want = '0;
      return st;
   endfunction

   function automatic step_type random_step();
      step_type st;
      int       pick;
      pick = $urandom_range(99);
      st = mk(KIND_SCHEDULE, $urandom, 6'($urandom_range(63)),
              {$urandom, $urandom}, 16'($urandom_range(65535)));
      // Mostly short positive delays so events really come due.
      if ($urandom_range(3) != 0)
         st.delay = $urandom_range(0, 3000) - ($urandom_range(7) == 0 ? 500 : 0);
      if ($urandom_range(2) != 0)
         st.remaining = 16'($urandom_range(0, 2000));
      st.evt_code = $urandom_range(1) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
      if (pick < 45)
         st.kind = KIND_SCHEDULE;
      else if (pick < 80)
         st.kind = KIND_ADVANCE;
      else if (pick < 90)
         st.kind = KIND_REMOVE;
      else
         st.kind = KIND_IDLE;
      return st;
   endfunction

   initial begin
      step_type st;
      rsp_type  w;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_SCHEDULE;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      mismatches = 0;
      timed_out = 1'b0;
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      predictor_reset();
      wait_cycles(3);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table. First row: advance right after reset with nothing queued.
      st = mk(KIND_ADVANCE, '0, '0, '0, 16'd0);
      st.has_want = 1'b1;
      w = '0;
      w.countdown = DEFAULT_SLICE;
      w.ticks = 63'd20000;
      w.last = 1'b1;
      st.want = w;
      dir_rows = {dir_rows, st};
      dir_rows = {dir_rows, mk(KIND_SCHEDULE, 32'd100, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 16'd500)};
      dir_rows = {dir_rows, mk(KIND_SCHEDULE, 32'd100, 6'd0, 64'd0, 16'hFFFF)};
      dir_rows = {dir_rows, mk(KIND_SCHEDULE, 32'h7FFF_FFFF, 6'd5, 64'h1234, 16'd0)};
      dir_rows = {dir_rows, mk(KIND_SCHEDULE, 32'h8000_0000, 6'd6, 64'h5555, 16'd10)};
      dir_rows = {dir_rows, mk(KIND_SCHEDULE, 32'hFFFF_FFFF, 6'd7, 64'hAAAA, 16'd3)};
      dir_rows = {dir_rows, mk(KIND_ADVANCE, '0, '0, '0, 16'd0)};
      dir_rows = {dir_rows, mk(KIND_ADVANCE, '0, '0, '0, 16'hFFFF)};
      dir_rows = {dir_rows, mk(KIND_SCHEDULE, 32'd20, 6'd9, 64'd9, 16'd40)};
      dir_rows = {dir_rows, mk(KIND_SCHEDULE, 32'd20, 6'd9, 64'd10, 16'd30)};
      dir_rows = {dir_rows, mk(KIND_REMOVE, '0, 6'd9, '0, 16'd7)};
      dir_rows = {dir_rows, mk(KIND_REMOVE, '0, 6'd63, '0, 16'd0)};
      dir_rows = {dir_rows, mk(KIND_IDLE, '0, '0, '0, 16'hFFFF)};
      dir_rows = {dir_rows, mk(KIND_IDLE, '0, '0, '0, 16'd0)};
      dir_rows = {dir_rows, mk(KIND_ADVANCE, '0, '0, '0, 16'd100)};
      foreach (dir_rows[i])
         send_step(dir_rows[i]);

      // Fill the queue past its depth so a schedule gets dropped.
      for (int i = 0; i < QDEPTH + 2; i++)
         send_step(mk(KIND_SCHEDULE, 32'd50, 6'(i), {$urandom, $urandom}, 16'd0));
      // Hold off until everything has drained, then fire all at once.
      drain_results();
      send_step(mk(KIND_ADVANCE, '0, '0, '0, 16'd0));
      send_step(mk(KIND_ADVANCE, '0, '0, '0, 16'd0));
      drain_results();

      // Random phases over several slice settings, extremes among them.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: write_max_slice(16'd1);
            1: write_max_slice(16'hFFFF);
            2: write_max_slice(16'd300 + 16'($urandom_range(2000)));
            default: write_max_slice(DEFAULT_SLICE);
         endcase
         req_quiet = (ph == 2);
         rsp_quiet = (ph == 3);
         for (int n = 0; n < 18; n++)
            send_step(random_step());
         drain_results();
      end

      wait_cycles(50);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("timed_event_scheduler_core_test OK");
      else
         $display("timed_event_scheduler_core_test NOT OK");
      $finish;
   end

   // Watchdog: worst case is far below this.
   always @(posedge clock) begin
      if (cycle_count > STALL_LIMIT) begin
         $display("timed_event_scheduler_core_test NOT OK");
         $finish;
      end
   end

endmodule
